// File: rtl/atp_pkg.sv
`default_nettype none

package atp_pkg;

   // Internal values are signed with 32 fraction bits
   localparam int VAL_W = 36;
   typedef logic signed [VAL_W-1:0] val_type;

   // Reciprocal divider geometry
   localparam int Z_W       = 32;
   localparam int QUO_W     = 33;
   localparam int DIV_CELLS = QUO_W;
   localparam logic [Z_W-1:0] REM_INIT = 32'h0000_8000;
   localparam logic [Z_W-1:0] ONE_Q16  = 32'h0001_0000;

   // Polynomial chain geometry
   localparam int MAC_STEPS = 16;
   localparam int NCOEF     = 19;

   // Angle constants
   localparam val_type PIO2_Q32 = 36'sd6746518852;
   localparam logic [31:0] ANGLE_MAX = 32'd1686629713;

   // One beat inside the divider
   typedef struct packed {
      logic [Z_W-1:0]   rem;
      logic [QUO_W-1:0] quo;
      logic [Z_W-1:0]   z;
      logic             negin;
      logic             reduce;
   } div_type;

   // One beat inside the polynomial chain
   typedef struct packed {
      val_type a;
      val_type s;
      val_type q;
      val_type p;
      val_type t;
      logic    negin;
      logic    reduce;
   } ctx_type;

   // Minimax coefficient rounded to Q.32; odd/even pairs first, then s-terms
   function automatic val_type coef_q32(input int idx);
      logic [53:0] mant;
      int          shr;
      logic        neg;
      logic [53:0] rnd;
      mant = '0;
      shr  = 1;
      neg  = 1'b0;
      case (idx)
         0:  begin mant = 54'h153e1d2a258e3a; shr = 36; neg = 1'b1; end
         1:  begin mant = 54'h1d3b63dbb6167a; shr = 33; neg = 1'b0; end
         2:  begin mant = 54'h1312788ddde71d; shr = 30; neg = 1'b1; end
         3:  begin mant = 54'h1f9690c824aaf1; shr = 29; neg = 1'b0; end
         4:  begin mant = 54'h12cf5aabc7dbd2; shr = 27; neg = 1'b1; end
         5:  begin mant = 54'h1162b0b2a3bcdc; shr = 26; neg = 1'b0; end
         6:  begin mant = 54'h1a7256feb6f841; shr = 26; neg = 1'b1; end
         7:  begin mant = 54'h1171560ce4a4ec; shr = 25; neg = 1'b0; end
         8:  begin mant = 54'h14f44d841450e8; shr = 25; neg = 1'b1; end
         9:  begin mant = 54'h17ee3d3f36bbc6; shr = 25; neg = 1'b0; end
         10: begin mant = 54'h1ad32ae04a9fd8; shr = 25; neg = 1'b1; end
         11: begin mant = 54'h1e17813d669537; shr = 25; neg = 1'b0; end
         12: begin mant = 54'h111089ca9a5be4; shr = 24; neg = 1'b1; end
         13: begin mant = 54'h13b12b2db5173c; shr = 24; neg = 1'b0; end
         14: begin mant = 54'h1745d022f8dc5f; shr = 24; neg = 1'b1; end
         15: begin mant = 54'h1c71c709dfe925; shr = 24; neg = 1'b0; end
         16: begin mant = 54'h12492491fa1742; shr = 23; neg = 1'b1; end
         17: begin mant = 54'h199999999840cd; shr = 23; neg = 1'b0; end
         18: begin mant = 54'h15555555555448; shr = 22; neg = 1'b1; end
         default: begin mant = '0; shr = 1; neg = 1'b0; end
      endcase
      rnd = (mant + (54'd1 << (shr - 1))) >> shr;
      return neg ? -val_type'(rnd) : val_type'(rnd);
   endfunction

endpackage

`default_nettype wire

// File: rtl/arctangent_polynomial.sv
`default_nettype none

// Arctangent of a signed Q16.16 tangent, returned in radians as signed Q1.30
// (clamped to +-pi/2). Fully pipelined: one beat is taken every cycle unless the
// row is halted; each beat passes the input register, 33 divider cells giving
// one reciprocal bit each, 16 multiply-add steps of the polynomial, and the
// output register. The whole row advances together and halts only while
// a result waits on the output and is not taken.
module arctangent_polynomial (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] argument
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [31:0] angle
);

   localparam int NSTG = 2 + atp_pkg::DIV_CELLS + 2 * atp_pkg::MAC_STEPS;

   logic                    adv;
   logic [NSTG-1:0]         v_ff, v_in;
   atp_pkg::div_type        d0_ff, d0_in;
   atp_pkg::div_type        dd [0:atp_pkg::DIV_CELLS];
   atp_pkg::ctx_type        ci [0:atp_pkg::MAC_STEPS];
   logic [32:0]             z_ext;
   atp_pkg::val_type        a_val;
   atp_pkg::val_type        r_fin, r_mag;
   logic [atp_pkg::VAL_W-1:0] rq;
   logic [31:0]             mag32;
   logic                    neg_fin;
   logic [31:0]             angle_ff, angle_in;

   // Global advance: move unless the output beat is stuck
   assign adv        = ~v_ff[NSTG-1] | rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = v_ff[NSTG-1];
   assign rsp_tdata  = angle_ff;

   // Valid bits
   assign v_in = {v_ff[NSTG-2:0], req_tvalid};
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // Input stage: magnitude, reduction flag, divider seed
   always_comb begin
      z_ext        = req_tdata[31] ? (33'h1_0000_0000 - {1'b0, req_tdata})
                                   : {1'b0, req_tdata};
      d0_in.z      = z_ext[31:0];
      d0_in.negin  = req_tdata[31];
      d0_in.reduce = z_ext[31:0] > atp_pkg::ONE_Q16;
      d0_in.rem    = atp_pkg::REM_INIT;
      d0_in.quo    = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d0_ff <= d0_in;
      end
   end

   assign dd[0] = d0_ff;

   // Reciprocal: (2^48 + z/2) / z, numerator low bits are z >> 1
   genvar g;
   generate
      for (g = 0; g < atp_pkg::DIV_CELLS; g++) begin : g_div
         logic nbit;
         if (atp_pkg::DIV_CELLS - g <= atp_pkg::Z_W - 1) begin : g_bit
            assign nbit = dd[g].z[atp_pkg::DIV_CELLS - g];
         end else begin : g_zero
            assign nbit = 1'b0;
         end
         atp_div_cell u_div (
            .clock   (clock),
            .enable  (adv),
            .d_in    (dd[g]),
            .num_bit (nbit),
            .d_out   (dd[g+1])
         );
      end
   endgenerate

   // Reduced value and chain seed
   always_comb begin
      a_val = dd[atp_pkg::DIV_CELLS].reduce
            ? atp_pkg::val_type'({3'b000, dd[atp_pkg::DIV_CELLS].quo})
            : atp_pkg::val_type'({dd[atp_pkg::DIV_CELLS].z, 16'h0000});
      ci[0].a      = a_val;
      ci[0].s      = '0;
      ci[0].q      = '0;
      ci[0].p      = atp_pkg::coef_q32(0);
      ci[0].t      = atp_pkg::coef_q32(1);
      ci[0].negin  = dd[atp_pkg::DIV_CELLS].negin;
      ci[0].reduce = dd[atp_pkg::DIV_CELLS].reduce;
   end

   // Polynomial: one multiply-add cell per step, two for the paired chains
   genvar k;
   generate
      for (k = 0; k < atp_pkg::MAC_STEPS; k++) begin : g_mac
         atp_pkg::val_type xa, ya, ad, r1;
         atp_pkg::ctx_type cm_ff, ce_ff;

         atp_mac_cell u_mac (
            .clock  (clock),
            .enable (adv),
            .x      (xa),
            .y      (ya),
            .addend (ad),
            .result (r1)
         );

         // Carry the context alongside the cell
         always_ff @(posedge clock) begin
            if (adv) begin
               cm_ff <= ci[k];
               ce_ff <= cm_ff;
            end
         end

         if (k == 0) begin : g_sq
            assign xa = ci[k].a;
            assign ya = ci[k].a;
            assign ad = '0;
            always_comb begin
               ci[k+1]   = ce_ff;
               ci[k+1].s = r1;
            end
         end else if (k == 1) begin : g_qd
            assign xa = ci[k].s;
            assign ya = ci[k].s;
            assign ad = '0;
            always_comb begin
               ci[k+1]   = ce_ff;
               ci[k+1].q = r1;
            end
         end else if (k < 8) begin : g_pair
            localparam atp_pkg::val_type CP = atp_pkg::coef_q32(2 * (k - 1));
            localparam atp_pkg::val_type CT = atp_pkg::coef_q32(2 * (k - 1) + 1);
            atp_pkg::val_type r2;
            atp_mac_cell u_mac_t (
               .clock  (clock),
               .enable (adv),
               .x      (ci[k].t),
               .y      (ci[k].q),
               .addend (CT),
               .result (r2)
            );
            assign xa = ci[k].p;
            assign ya = ci[k].q;
            assign ad = CP;
            always_comb begin
               ci[k+1]   = ce_ff;
               ci[k+1].p = r1;
               ci[k+1].t = r2;
            end
         end else if (k == 8) begin : g_merge
            assign xa = ci[k].p;
            assign ya = ci[k].s;
            assign ad = ci[k].t;
            always_comb begin
               ci[k+1]   = ce_ff;
               ci[k+1].p = r1;
            end
         end else if (k < 14) begin : g_sterm
            localparam atp_pkg::val_type CS = atp_pkg::coef_q32(k + 5);
            assign xa = ci[k].p;
            assign ya = ci[k].s;
            assign ad = CS;
            always_comb begin
               ci[k+1]   = ce_ff;
               ci[k+1].p = r1;
            end
         end else if (k == 14) begin : g_last_s
            assign xa = ci[k].p;
            assign ya = ci[k].s;
            assign ad = '0;
            always_comb begin
               ci[k+1]   = ce_ff;
               ci[k+1].p = r1;
            end
         end else begin : g_scale
            assign xa = ci[k].p;
            assign ya = ci[k].a;
            assign ad = ci[k].a;
            always_comb begin
               ci[k+1]   = ce_ff;
               ci[k+1].p = r1;
            end
         end
      end
   endgenerate

   // Output stage: fold back from pi/2, round to Q1.30, clamp, restore sign
   always_comb begin
      r_fin   = ci[atp_pkg::MAC_STEPS].reduce ? atp_pkg::PIO2_Q32 - ci[atp_pkg::MAC_STEPS].p
                                              : ci[atp_pkg::MAC_STEPS].p;
      r_mag   = r_fin[atp_pkg::VAL_W-1] ? -r_fin : r_fin;
      rq      = (r_mag + atp_pkg::val_type'(2)) >> 2;
      mag32   = (rq > {{(atp_pkg::VAL_W-32){1'b0}}, atp_pkg::ANGLE_MAX})
              ? atp_pkg::ANGLE_MAX : rq[31:0];
      neg_fin = r_fin[atp_pkg::VAL_W-1] ^ ci[atp_pkg::MAC_STEPS].negin;
      angle_in = neg_fin ? -mag32 : mag32;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= angle_in;
      end
   end

   // Result stays within the clamp
   a_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata) <= $signed(atp_pkg::ANGLE_MAX)) &&
                     ($signed(rsp_tdata) >= -$signed(atp_pkg::ANGLE_MAX)))
      else $error("angle outside clamp range");

   // A stalled row keeps all its valid bits
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(v_ff))
      else $error("pipeline moved while output stalled");

   // An advancing row shifts its valid bits by one stage
   a_shift : assert property (@(posedge clock) disable iff (reset)
      (adv && !$past(reset)) |=> (v_ff[NSTG-1:1] == $past(v_ff[NSTG-2:0])))
      else $error("valid bits lost or duplicated");

endmodule

`default_nettype wire

// File: rtl/atp_div_cell.sv
`default_nettype none

// One restoring step of the reciprocal divider: one quotient bit per cell
module atp_div_cell (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire atp_pkg::div_type  d_in,
   input  wire logic              num_bit,
   output atp_pkg::div_type       d_out
);

   atp_pkg::div_type     d_ff, d_in_next;
   logic [atp_pkg::Z_W:0] rem_sh;
   logic [atp_pkg::Z_W:0] diff;
   logic                  ge;

   // Shift in the next numerator bit, trial subtract the divisor
   always_comb begin
      rem_sh    = {d_in.rem, num_bit};
      diff      = rem_sh - {1'b0, d_in.z};
      ge        = rem_sh >= {1'b0, d_in.z};
      d_in_next = d_in;
      d_in_next.rem = ge ? diff[atp_pkg::Z_W-1:0] : rem_sh[atp_pkg::Z_W-1:0];
      d_in_next.quo = {d_in.quo[atp_pkg::QUO_W-2:0], ge};
   end

   // Hand the beat to the next cell
   always_ff @(posedge clock) begin
      if (enable) begin
         d_ff <= d_in_next;
      end
   end

   assign d_out = d_ff;

endmodule

`default_nettype wire

// File: rtl/atp_mac_cell.sv
`default_nettype none

// Pipelined multiply-add: result = round(x*y / 2^32) + addend
module atp_mac_cell (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire atp_pkg::val_type x,
   input  wire atp_pkg::val_type y,
   input  wire atp_pkg::val_type addend,
   output atp_pkg::val_type      result
);

   atp_pkg::val_type xn, yn;
   logic [32:0] xm, ym;
   logic [65:0] prod_ff, prod_in;
   logic        neg_ff, neg_in;
   atp_pkg::val_type add_ff;
   logic [65:0] prod_rnd;
   atp_pkg::val_type mag, result_ff, result_in;

   // Sign and magnitude of the operands, 33 magnitude bits kept
   always_comb begin
      xn      = -x;
      yn      = -y;
      xm      = x[atp_pkg::VAL_W-1] ? xn[32:0] : x[32:0];
      ym      = y[atp_pkg::VAL_W-1] ? yn[32:0] : y[32:0];
      prod_in = {33'd0, xm} * {33'd0, ym};
      neg_in  = x[atp_pkg::VAL_W-1] ^ y[atp_pkg::VAL_W-1];
   end

   // Round to nearest, ties away from zero, restore sign, add
   always_comb begin
      prod_rnd  = prod_ff + 66'h0_8000_0000;
      mag       = atp_pkg::val_type'({2'b00, prod_rnd[65:32]});
      result_in = (neg_ff ? -mag : mag) + add_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff   <= prod_in;
         neg_ff    <= neg_in;
         add_ff    <= addend;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY    = 67;
   localparam int IDLE_LIMIT = 4000;
   localparam longint HALF_PI_Q32   = 64'sd6746518852;
   localparam longint ANGLE_LIMIT   = 64'sd1686629713;

   // Minimax coefficients: 53-bit mantissa, right shift to Q.32, sign
   localparam logic [63:0] COEF_MANT [0:18] = '{
      64'h153e1d2a258e3a, 64'h1d3b63dbb6167a, 64'h1312788ddde71d,
      64'h1f9690c824aaf1, 64'h12cf5aabc7dbd2, 64'h1162b0b2a3bcdc,
      64'h1a7256feb6f841, 64'h1171560ce4a4ec, 64'h14f44d841450e8,
      64'h17ee3d3f36bbc6, 64'h1ad32ae04a9fd8, 64'h1e17813d669537,
      64'h111089ca9a5be4, 64'h13b12b2db5173c, 64'h1745d022f8dc5f,
      64'h1c71c709dfe925, 64'h12492491fa1742, 64'h199999999840cd,
      64'h15555555555448};
   localparam int COEF_SHIFT [0:18] = '{36, 33, 30, 29, 27, 26, 26, 25, 25, 25,
                                        25, 25, 24, 24, 24, 24, 23, 23, 22};
   localparam bit COEF_NEG [0:18] = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0,
                                      1, 0, 1, 0, 1, 0, 1, 0, 1};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] argument
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [31:0] rsp_tdata;   // [31:0] angle

   logic [31:0] angle_queue [$];
   int          mismatch_count = 0;
   int          beats_in = 0;
   int          beats_out = 0;
   int          reduced_count = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;

   arctangent_polynomial dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint coef_at(int i);
      logic [63:0] m;
      m = (COEF_MANT[i] + (64'd1 << (COEF_SHIFT[i] - 1))) >> COEF_SHIFT[i];
      return COEF_NEG[i] ? -longint'(m) : longint'(m);
   endfunction

   // Q.32 product, rounded to nearest with ties away from zero
   function automatic longint mul_fix(longint x, longint y);
      logic        neg;
      logic [63:0] ux, uy, xh, xl, yh, yl, lo, m;
      neg = (x < 0) != (y < 0);
      ux  = (x < 0) ? 64'(-x) : 64'(x);
      uy  = (y < 0) ? 64'(-y) : 64'(y);
      ux  = ux & 64'h1_FFFF_FFFF;
      uy  = uy & 64'h1_FFFF_FFFF;
      xh  = ux >> 32;
      xl  = ux & 64'hFFFF_FFFF;
      yh  = uy >> 32;
      yl  = uy & 64'hFFFF_FFFF;
      lo  = (xl * yl + 64'h8000_0000) >> 32;
      m   = xh * uy + xl * yh + lo;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [31:0] predict_angle(logic [31:0] arg);
      logic        negin, reduce;
      logic [63:0] z, ur;
      longint      a, s, q, p, t, r;
      negin  = arg[31];
      z      = negin ? ((64'h1_0000_0000 - {32'd0, arg}) & 64'h1_FFFF_FFFF) : {32'd0, arg};
      reduce = z > 64'd65536;
      if (reduce) a = longint'(((64'd1 << 48) + (z >> 1)) / z);
      else        a = longint'(z << 16);
      s = mul_fix(a, a);
      q = mul_fix(s, s);
      p = coef_at(0);
      t = coef_at(1);
      for (int i = 1; i < 7; i++) begin
         p = mul_fix(p, q) + coef_at(2 * i);
         t = mul_fix(t, q) + coef_at(2 * i + 1);
      end
      p = mul_fix(p, s) + t;
      for (int i = 14; i < 19; i++) p = mul_fix(p, s) + coef_at(i);
      p = mul_fix(mul_fix(p, s), a) + a;
      r = reduce ? HALF_PI_Q32 - p : p;
      if (r < 0) begin
         ur = (64'(-r) + 64'd2) >> 2;
         r  = -longint'(ur);
      end else begin
         ur = (64'(r) + 64'd2) >> 2;
         r  = longint'(ur);
      end
      if (r > ANGLE_LIMIT)  r = ANGLE_LIMIT;
      if (r < -ANGLE_LIMIT) r = -ANGLE_LIMIT;
      if (negin) r = -r;
      return r[31:0];
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drive one argument beat and hold it until taken
   task automatic send_argument(logic [31:0] arg);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= arg;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Argument near the reduction boundary, tiny or huge, or fully random
   function automatic logic [31:0] pick_argument();
      int          roll;
      logic [31:0] v;
      roll = $urandom_range(0, 99);
      if (roll < 40) v = $urandom;
      else if (roll < 65) v = 32'h0001_0000 + $urandom_range(0, 64) - 32;
      else if (roll < 80) v = $urandom_range(0, 32'h0002_0000);
      else if (roll < 90) v = $urandom_range(0, 255);
      else v = 32'h7FFF_0000 + $urandom_range(0, 32'h0001_FFFF);
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   task automatic test_directed();
      logic [31:0] vals [$];
      vals = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_FFFF,
               32'h0001_0000, 32'hFFFF_0000, 32'h0001_0001, 32'hFFFE_FFFF,
               32'h0000_8000, 32'h0002_0000, 32'h0010_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0001, 32'h7FFF_0000, 32'h0000_4000,
               32'h0001_bb67, 32'hFFFF_7FFF, 32'h5555_5555, 32'hAAAA_AAAA};
      foreach (vals[i]) send_argument(vals[i]);
   endtask

   task automatic test_random_arguments(int count);
      repeat (count) send_argument(pick_argument());
   endtask

   // Back-to-back burst with no source gaps
   task automatic test_burst(int count);
      repeat (count) begin
         req_tvalid <= 1'b1;
         req_tdata  <= pick_argument();
         @(negedge clock);
         while (!req_tready) @(negedge clock);
         @(posedge clock);
      end
      req_tvalid <= 1'b0;
   endtask

   // Record expected angle for every accepted argument
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         angle_queue.push_back(predict_angle(req_tdata));
         beats_in <= beats_in + 1;
         if ((req_tdata[31] ? -req_tdata : req_tdata) > 32'h0001_0000)
            reduced_count <= reduced_count + 1;
      end
   end

   // Compare each angle beat with the oldest expectation
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_out <= beats_out + 1;
         if (angle_queue.size() == 0) begin
            $error("angle beat with nothing expected: actual %0d", $signed(rsp_tdata));
            mismatch_count <= mismatch_count + 1;
         end else begin
            want = angle_queue.pop_front();
            if (rsp_tdata !== want) begin
               $error("angle: expected %0d actual %0d", $signed(want), $signed(rsp_tdata));
               mismatch_count <= mismatch_count + 1;
            end
         end
      end
   end

   // Random back-pressure, with calm stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if ($urandom_range(0, 99) < 20) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Stop the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: %0d results outstanding", angle_queue.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_arguments(1200);
      test_burst(200);
      test_random_arguments(230);

      req_tvalid <= 1'b0;
      while (angle_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("covered %0d arguments (%0d by reciprocal reduction), %0d angles checked",
               beats_in, reduced_count, beats_out);
      $display("stimulus: edge values, boundary at one, full-range random, bursts, stalls");
      if (mismatch_count == 0 && angle_queue.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
